[sv/xbm_pkg.sv]
// xbm_pkg: shared constants, codes and types of the xorshift byte MAC engine.
// Used by xbm_ctrl, xbm_dp and xorshift_byte_mac_engine. Depends on nothing.
package xbm_pkg;

	localparam logic [63:0] SEED_CONST  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MUL_CONST   = 64'h2545_F491_4F6C_DD1D;
	localparam int          SHIFT_A     = 12;
	localparam int          SHIFT_B     = 25;
	localparam int          SHIFT_C     = 27;
	localparam int          COUNT_MAX   = 2047;
	localparam int          CNT_W       = 11;
	localparam int          MAC_BYTES_DEF = 16;
	localparam int          BLOB_BYTES  = 1024;

	// configuration register indexes
	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_TWEAK    = 2'd1;
	localparam logic [1:0] REG_ABSORB   = 2'd2;
	localparam logic [1:0] REG_EXP_TYPE = 2'd3;

	typedef enum logic [2:0] {
		ST_BYTE = 3'd0,
		ST_OK   = 3'd1,
		ST_TYPE = 3'd2,
		ST_MAC  = 3'd3,
		ST_LEN  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_POST,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		K_ABSORB,
		K_COMPARE,
		K_SQUEEZE,
		K_VERDICT
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // latch input word
		logic count_step; // advance byte count
		logic mul_a;      // xorshift + low partial product
		logic mul_b;      // high x low cross product
		logic mul_c;      // low x high cross product, state update
		logic use_byte;   // xor input byte into state in mul_a
		logic compare;    // check squeezed byte against input byte in mul_c
		logic emit;       // load output register
		logic verdict;    // output word is a verdict
		logic sq_last;    // final squeezed byte of the run
		logic restart;    // back to message start
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mode;
		logic last;
		logic absorb;  // byte count below absorb length
		logic in_mac;  // byte count below absorb length + MAC bytes
	} sts_t;

	function automatic logic [63:0] xs_shift(input logic [63:0] x);
		logic [63:0] y;
		y = x ^ (x >> SHIFT_A);
		y = y ^ (y << SHIFT_B);
		y = y ^ (y >> SHIFT_C);
		return y;
	endfunction

endpackage

[sv/xbm_ctrl.sv]
// xbm_ctrl: sequencer of the xorshift byte MAC engine and output valid flag.
// Depends on xbm_pkg.
module xbm_ctrl #(
	parameter int MAC_BYTES = xbm_pkg::MAC_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  xbm_pkg::sts_t sts,
	output xbm_pkg::cmd_t cmd
);
	import xbm_pkg::*;

	localparam int SQ_W = (MAC_BYTES > 1) ? $clog2(MAC_BYTES) : 1;
	localparam logic [SQ_W-1:0] SQ_LAST = SQ_W'(MAC_BYTES - 1);

	state_t          state_q, state_d;
	kind_t           kind_q, kind_d;
	logic [SQ_W-1:0] sq_q, sq_d;
	logic            out_valid_q;
	logic            slot_free;
	logic            run_done;

	assign slot_free = !out_valid_q || !out_stall;
	assign run_done  = (kind_q == K_VERDICT) || (sq_q == SQ_LAST);

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		sq_d    = sq_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.absorb) begin
					kind_d  = K_ABSORB;
					state_d = S_MUL_A;
				end else if (sts.mode && sts.in_mac) begin
					kind_d  = K_COMPARE;
					state_d = S_MUL_A;
				end else begin
					state_d = S_POST;
				end
			end
			S_MUL_A: state_d = S_MUL_B;
			S_MUL_B: state_d = S_MUL_C;
			S_MUL_C: begin
				state_d = (kind_q == K_SQUEEZE) ? S_EMIT : S_POST;
			end
			S_POST: begin
				if (!sts.mode && !sts.absorb) begin
					kind_d  = K_SQUEEZE;
					sq_d    = '0;
					state_d = S_MUL_A;
				end else if (sts.last) begin
					kind_d  = K_VERDICT;
					state_d = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					if (run_done) begin
						state_d = S_IDLE;
					end else begin
						sq_d    = sq_q + 1'b1;
						state_d = S_MUL_A;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == S_IDLE) && in_valid;
		cmd.count_step = (state_q == S_CHECK);
		cmd.mul_a      = (state_q == S_MUL_A);
		cmd.mul_b      = (state_q == S_MUL_B);
		cmd.mul_c      = (state_q == S_MUL_C);
		cmd.use_byte   = (state_q == S_MUL_A) && (kind_q == K_ABSORB);
		cmd.compare    = (state_q == S_MUL_C) && (kind_q == K_COMPARE);
		cmd.emit       = (state_q == S_EMIT) && slot_free;
		cmd.verdict    = (kind_q == K_VERDICT);
		cmd.sq_last    = (sq_q == SQ_LAST);
		cmd.restart    = (state_q == S_EMIT) && slot_free && run_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_ABSORB;
			sq_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			sq_q    <= sq_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[sv/xbm_dp.sv]
// xbm_dp: datapath of the xorshift byte MAC engine: config registers, mixer
// state, shared 32x32 multiplier, message counters and output word register.
// Depends on xbm_pkg.
module xbm_dp #(
	parameter int MAC_BYTES = xbm_pkg::MAC_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data,
	input  logic [7:0]    data_byte,
	input  logic          last,
	input  xbm_pkg::cmd_t cmd,
	output xbm_pkg::sts_t sts,
	output logic [7:0]    out_byte,
	output logic [2:0]    status,
	output logic          last_out
);
	import xbm_pkg::*;

	localparam int ABSORB_RAW = BLOB_BYTES - MAC_BYTES;
	localparam logic [CNT_W-1:0] ABSORB_RST =
		CNT_W'((ABSORB_RAW > COUNT_MAX) ? COUNT_MAX : ABSORB_RAW);
	localparam logic [CNT_W-1:0] ALEN_MAX = CNT_W'(COUNT_MAX - MAC_BYTES);
	localparam logic [CNT_W-1:0] MAC_LEN  = CNT_W'(MAC_BYTES);
	localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(COUNT_MAX);

	// configuration
	logic             mode_q;
	logic [63:0]      tweak_q;
	logic [CNT_W-1:0] absorb_q;
	logic [31:0]      exp_type_q;

	// message state
	logic [63:0]      mix_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      tag_q;
	logic             mac_eq_q;
	logic [7:0]       byte_q;
	logic             last_q;

	// multiplier operands and partial sums
	logic [63:0]      x_q;
	logic [63:0]      acc_q;
	logic [63:0]      x_new;
	logic [31:0]      op_a, op_b;
	logic [63:0]      prod;

	logic [CNT_W-1:0] alen;
	logic [CNT_W-1:0] alen_mac;
	logic             absorb;
	status_t          verdict;

	always_comb begin
		alen = absorb_q;
		if (alen == '0) begin
			alen = CNT_W'(1);
		end
		if (alen > ALEN_MAX) begin
			alen = ALEN_MAX;
		end
	end

	assign alen_mac   = alen + MAC_LEN;
	assign absorb     = (cnt_q < alen);
	assign sts.mode   = mode_q;
	assign sts.last   = last_q;
	assign sts.absorb = absorb;
	assign sts.in_mac = (cnt_q < alen_mac);

	assign x_new = xs_shift(mix_q ^ (cmd.use_byte ? {56'd0, byte_q} : 64'd0));

	always_comb begin
		if (cmd.mul_a) begin
			op_a = x_new[31:0];
			op_b = MUL_CONST[31:0];
		end else if (cmd.mul_b) begin
			op_a = x_q[63:32];
			op_b = MUL_CONST[31:0];
		end else begin
			op_a = x_q[31:0];
			op_b = MUL_CONST[63:32];
		end
	end

	assign prod = op_a * op_b;

	always_comb begin
		if (!mode_q || (cnt_q != alen_mac)) begin
			verdict = ST_LEN;
		end else if (tag_q != exp_type_q) begin
			verdict = ST_TYPE;
		end else if (!mac_eq_q) begin
			verdict = ST_MAC;
		end else begin
			verdict = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			tweak_q    <= '0;
			absorb_q   <= ABSORB_RST;
			exp_type_q <= '0;
			cnt_q      <= '0;
			tag_q      <= '0;
			mac_eq_q   <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:     mode_q     <= cfg_data[0];
					REG_TWEAK:    tweak_q    <= cfg_data;
					REG_ABSORB:   absorb_q   <= cfg_data[CNT_W-1:0];
					REG_EXP_TYPE: exp_type_q <= cfg_data[31:0];
					default:      mode_q     <= mode_q;
				endcase
			end
			if (cmd.restart) begin
				cnt_q    <= '0;
				tag_q    <= '0;
				mac_eq_q <= 1'b1;
			end else begin
				if (cmd.accept && (cnt_q < CNT_W'(4))) begin
					tag_q[8*cnt_q[1:0] +: 8] <= tag_q[8*cnt_q[1:0] +: 8] | data_byte;
				end
				if (cmd.count_step) begin
					if (mode_q) begin
						if (cnt_q != CNT_TOP) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (absorb) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				if (cmd.compare && (acc_q[7:0] != byte_q)) begin
					mac_eq_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= data_byte;
			last_q <= last;
			if (cnt_q == '0) begin
				mix_q <= SEED_CONST ^ tweak_q;
			end
		end
		if (cmd.mul_a) begin
			x_q   <= x_new;
			acc_q <= prod;
		end
		if (cmd.mul_b) begin
			acc_q[63:32] <= acc_q[63:32] + prod[31:0];
		end
		if (cmd.mul_c) begin
			mix_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
		end
		if (cmd.emit) begin
			if (cmd.verdict) begin
				out_byte <= 8'd0;
				status   <= verdict;
				last_out <= 1'b1;
			end else begin
				out_byte <= mix_q[7:0];
				status   <= ST_BYTE;
				last_out <= cmd.sq_last;
			end
		end
	end

endmodule

[sv/xorshift_byte_mac_engine.sv]
// xorshift_byte_mac_engine: top level of the byte-serial xorshift64* MAC and
// fingerprint engine. Depends on xbm_pkg, xbm_ctrl and xbm_dp.
//
// Usage
//   Input channel: data_byte/last, handshake in_valid/in_stall. A word is
//   taken on a rising edge with in_valid high and in_stall low; one message
//   byte per word, last marks the final byte.
//   Output channel: out_byte/status/last_out, handshake out_valid/out_stall.
//   Squeezed bytes carry status 0; verdicts carry out_byte 0, last_out 1.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 mode, 1 seed_tweak,
//   2 absorb_len, 3 type tag) and cfg_data. cfg_ready is always high; write
//   only while the engine is idle.
// Sequencing
//   Each xorshift64* step runs on one shared 32x32 multiplier: low x low,
//   then the two cross products. A byte that is absorbed or compared holds
//   in_stall through S_CHECK, S_MUL_A, S_MUL_B, S_MUL_C and S_POST, so no
//   new word is taken before the engine is through with the last one. A
//   generate run then squeezes MAC_BYTES bytes, each through the multiply
//   states and S_EMIT. A verdict is loaded in S_EMIT after the last byte.
// Reset and stall
//   arst_n clears sequencer, counters and config registers (absorb_len =
//   BLOB_BYTES - MAC_BYTES); no clearing pass. One output register holds the
//   result word; under out_stall the engine waits before loading the next
//   one, and input bytes that produce no result are still taken.
module xorshift_byte_mac_engine #(
	parameter int MAC_BYTES = xbm_pkg::MAC_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [2:0]  status,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import xbm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	xbm_ctrl #(
		.MAC_BYTES (MAC_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	xbm_dp #(
		.MAC_BYTES (MAC_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.data_byte (data_byte),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts),
		.out_byte  (out_byte),
		.status    (status),
		.last_out  (last_out)
	);

	// a verdict always closes the run
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_BYTE)) |-> last_out)
		else $error("verdict without last_out");

	// verdicts carry a zero byte
	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_BYTE)) |-> (out_byte == 8'd0))
		else $error("verdict with nonzero out_byte");

	// a result is loaded only while the engine is busy with a byte
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> in_stall)
		else $error("result loaded while idle");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_LEN))
		else $error("undefined status code");

endmodule

[test/xorshift_byte_mac_engine_tb.sv]
// Self-checking bench for xorshift_byte_mac_engine: byte messages in generate and verify mode,
// with a scoreboard that predicts every squeezed byte and verdict and checks them in order.
// Depends on xbm_pkg and the engine RTL.

typedef logic [7:0] msg_q_t[$];

typedef enum logic {
	MODE_GEN    = 1'b0,
	MODE_VERIFY = 1'b1
} run_mode_t;

typedef enum int {
	SHAPE_GOOD,
	SHAPE_BAD_TYPE,
	SHAPE_BAD_MAC,
	SHAPE_BAD_LEN,
	SHAPE_NOISE
} shape_t;

typedef struct packed {
	logic [7:0]       ob;
	xbm_pkg::status_t code;
	logic             tail;
} word_t;

class mac_scoreboard;
	localparam int MB   = xbm_pkg::MAC_BYTES_DEF;
	localparam int CMAX = xbm_pkg::COUNT_MAX;

	// live copy of the config registers
	logic        mode;
	logic [63:0] tweak;
	logic [10:0] absorb;
	logic [31:0] exp_type;

	// message state
	logic [63:0] mix;
	int          count;
	logic [31:0] tag;
	logic        mac_ok;

	logic [7:0]  mac_buf[MB];
	word_t       due_q[$];
	int          fails;

	function new();
		mode     = MODE_GEN;
		tweak    = '0;
		absorb   = 11'(xbm_pkg::BLOB_BYTES - MB);
		exp_type = '0;
		fails    = 0;
		restart();
	endfunction

	function void restart();
		mix    = xbm_pkg::SEED_CONST ^ tweak;
		count  = 0;
		tag    = '0;
		mac_ok = 1'b1;
	endfunction

	function logic [63:0] mix_step(input logic [63:0] v);
		logic [63:0] x;
		x = v;
		x = x ^ (x >> xbm_pkg::SHIFT_A);
		x = x ^ (x << xbm_pkg::SHIFT_B);
		x = x ^ (x >> xbm_pkg::SHIFT_C);
		return x * xbm_pkg::MUL_CONST;
	endfunction

	// zero acts as one, anything above COUNT_MAX - MB is clipped to it
	function int eff_len();
		int a;
		a = int'(absorb);
		if (a == 0) a = 1;
		if (a > CMAX - MB) a = CMAX - MB;
		return a;
	endfunction

	function void due(input logic [7:0] ob, input xbm_pkg::status_t code, input logic tail);
		word_t w;
		w.ob   = ob;
		w.code = code;
		w.tail = tail;
		due_q.push_back(w);
	endfunction

	// MAC of the first n bytes of m under the given tweak, left in mac_buf
	function void calc_mac(input msg_q_t m, input logic [63:0] tw, input int n);
		logic [63:0] st;
		st = xbm_pkg::SEED_CONST ^ tw;
		for (int i = 0; i < n; i++) st = mix_step(st ^ 64'(m[i]));
		for (int k = 0; k < MB; k++) begin
			st = mix_step(st);
			mac_buf[k] = st[7:0];
		end
	endfunction

	function void note_input(input logic [7:0] b, input logic lst);
		int               alen;
		int               pos;
		logic [63:0]      st;
		xbm_pkg::status_t verdict;
		alen = eff_len();
		pos  = count;
		st   = (pos == 0) ? (xbm_pkg::SEED_CONST ^ tweak) : mix;
		if (pos < 4) tag = tag | (32'(b) << (8 * pos));

		if (mode == MODE_GEN) begin
			if (pos < alen) begin
				st = mix_step(st ^ 64'(b));
				pos++;
			end
			if (pos >= alen) begin
				for (int k = 0; k < MB; k++) begin
					st = mix_step(st);
					due(st[7:0], xbm_pkg::ST_BYTE, k == MB - 1);
				end
				restart();
				return;
			end
			if (lst) begin
				due(8'h00, xbm_pkg::ST_LEN, 1'b1);
				restart();
				return;
			end
			mix   = st;
			count = pos;
			return;
		end

		if (pos < alen) begin
			st = mix_step(st ^ 64'(b));
		end else if (pos < alen + MB) begin
			st = mix_step(st);
			if (st[7:0] != b) mac_ok = 1'b0;
		end
		if (pos < CMAX) pos++;

		if (lst) begin
			if (pos != alen + MB)     verdict = xbm_pkg::ST_LEN;
			else if (tag != exp_type) verdict = xbm_pkg::ST_TYPE;
			else if (!mac_ok)         verdict = xbm_pkg::ST_MAC;
			else                      verdict = xbm_pkg::ST_OK;
			due(8'h00, verdict, 1'b1);
			restart();
			return;
		end
		mix   = st;
		count = pos;
	endfunction

	function void check(input logic [7:0] ob, input logic [2:0] code, input logic tail);
		word_t e;
		if (due_q.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected output word: out_byte %02h status %0d last_out %0b",
					ob, code, tail);
			return;
		end
		e = due_q.pop_front();
		if (e.ob !== ob || e.code !== code || e.tail !== tail) begin
			fails++;
			if (fails <= 10)
				$display("output mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
					e.ob, e.code, e.tail, ob, code, tail);
		end
	endfunction
endclass

module xorshift_byte_mac_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xbm_pkg::*;

	localparam int MB       = MAC_BYTES_DEF;
	// longest quiet spell after the last due word: a full squeeze run plus slack
	localparam int HOLD     = 6 + 4 * MB + 16;
	localparam int LIMIT    = 600000;
	localparam int IDLE_PCT = 9;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last      = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [2:0]  status;
	logic        last_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_MODE;
	logic [63:0] cfg_data  = '0;

	// calm: no idle gaps on the input, no stalls on the output
	logic        calm   = 1'b0;
	int          cycles = 0;
	int          pushed = 0;

	mac_scoreboard sb = new();

	xorshift_byte_mac_engine #(
		.MAC_BYTES(MB)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.status   (status),
		.last_out (last_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) cycles <= cycles + 1;

	// Output side: values read right after the edge are the pre-edge ones,
	// so a word counts as taken exactly when the engine sees valid & !stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(out_byte, status, last_out);
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Sends one message a word at a time. Valid stays up between words unless
	// a gap is drawn; it is only dropped in a step where it is not raised.
	task automatic send_msg(input msg_q_t m, input logic mark);
		int gap;
		foreach (m[i]) begin
			gap = 0;
			if (!calm)
				while ($urandom_range(99) < IDLE_PCT) gap++;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= m[i];
			last      <= mark && (i == m.size() - 1);
			do @(posedge clk); while (in_stall);
			sb.note_input(m[i], mark && (i == m.size() - 1));
			pushed++;
		end
	endtask

	// Drop valid, let every due word come out, then give the engine time to
	// finish a byte that produces nothing before the config is touched.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (HOLD) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:     sb.mode     = val[0];
			REG_TWEAK:    sb.tweak    = val;
			REG_ABSORB:   sb.absorb   = val[10:0];
			REG_EXP_TYPE: sb.exp_type = val[31:0];
			default: ;
		endcase
	endtask

	// writes all four registers back to back; valid drops after the last one
	task automatic configure(input logic md, input logic [63:0] tw, input logic [10:0] al,
			input logic [31:0] et);
		cfg_write(REG_MODE, 64'(md));
		cfg_write(REG_TWEAK, tw);
		cfg_write(REG_ABSORB, 64'(al));
		cfg_write(REG_EXP_TYPE, 64'(et));
		cfg_valid <= 1'b0;
	endtask

	initial begin : watchdog
		while (cycles < LIMIT) @(posedge clk);
		$display("xorshift_byte_mac_engine_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		msg_q_t      m;
		int          n;
		int          r;
		int          at;
		shape_t      shape;
		logic        mark;
		logic [10:0] al;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: generate mode, no tweak, absorb length BLOB_BYTES - MAC_BYTES.
		// A short message marked last ends long before the absorb region.
		// Run without any idling.
		calm = 1'b1;
		repeat (40) m.push_back(8'($urandom));
		send_msg(m, 1'b1);
		calm = 1'b0;
		settle();

		// --- directed part ---
		configure(MODE_GEN, 64'd0, 11'd3, 32'd0);
		m = '{8'h00, 8'hFF, 8'h80};
		send_msg(m, 1'b1);             // squeeze on a byte that is also last
		m = '{8'h7F, 8'h01, 8'hFE};
		send_msg(m, 1'b0);             // squeeze without last
		m = '{8'h55, 8'hAA};
		send_msg(m, 1'b1);             // last before the absorb region is full
		m = '{8'hFF};
		send_msg(m, 1'b1);             // last on the very first byte
		settle();

		configure(MODE_GEN, 64'd0, 11'd0, 32'd0);   // zero length acts as one
		m = '{8'hA5};
		send_msg(m, 1'b0);
		settle();

		configure(MODE_GEN, 64'd2, 11'd2, 32'd0);   // fingerprint: tweak == length
		m = '{8'h12, 8'h34};
		send_msg(m, 1'b0);
		settle();

		// Switch to generate halfway through a verify message that is already
		// past its absorb region: the next byte squeezes right away.
		configure(MODE_VERIFY, 64'd0, 11'd2, 32'd0);
		m = '{8'h01, 8'h02, 8'h03};
		send_msg(m, 1'b0);
		settle();
		configure(MODE_GEN, 64'd0, 11'd2, 32'd0);
		m = '{8'h04};
		send_msg(m, 1'b0);
		settle();

		// Verify with a one-byte absorb region: the tag spans MAC bytes, so
		// the expected tag is taken from the message itself.
		m = '{8'hC3};
		sb.calc_mac(m, 64'd0, 1);
		foreach (sb.mac_buf[i]) m.push_back(sb.mac_buf[i]);
		configure(MODE_VERIFY, 64'd0, 11'd1, {m[3], m[2], m[1], m[0]});
		send_msg(m, 1'b1);
		m = '{8'h01, 8'h02};
		send_msg(m, 1'b1);             // too short: tag never completes
		settle();

		// --- extremes ---
		// all-ones tweak and tag, good message
		m = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		sb.calc_mac(m, '1, 4);
		foreach (sb.mac_buf[i]) m.push_back(sb.mac_buf[i]);
		configure(MODE_VERIFY, '1, 11'd4, '1);
		send_msg(m, 1'b1);
		settle();

		// absorb field all ones clips to COUNT_MAX - MAC_BYTES;
		// a short message marked last ends early
		configure(MODE_GEN, '1, 11'h7FF, '1);
		m.delete();
		repeat (5) m.push_back(8'($urandom));
		send_msg(m, 1'b1);
		settle();

		// --- random phases ---
		// Mostly well-formed messages with random content; the rest are
		// corrupted tags, MACs or lengths, and plain noise.
		while (pushed < 250) begin
			if ($urandom_range(3) == 0) al = 11'($urandom_range(0, 40));
			else                        al = 11'($urandom_range(1, 12));
			configure(1'($urandom_range(1)), {$urandom, $urandom}, al, $urandom);
			calm = ($urandom_range(5) == 0);
			repeat ($urandom_range(2, 5)) begin
				m.delete();
				n    = sb.eff_len();
				r    = $urandom_range(9);
				mark = 1'b1;
				if (r < 6)       shape = SHAPE_GOOD;
				else if (r == 6) shape = SHAPE_BAD_TYPE;
				else if (r == 7) shape = SHAPE_BAD_MAC;
				else if (r == 8) shape = SHAPE_BAD_LEN;
				else             shape = SHAPE_NOISE;

				if (sb.mode == MODE_GEN) begin
					// early last, or a full region with last set or not
					if (r >= 8 && n > 1) n = $urandom_range(1, n - 1);
					else                 mark = 1'($urandom_range(1));
					repeat (n) m.push_back(8'($urandom));
				end else if (shape == SHAPE_NOISE) begin
					repeat ($urandom_range(1, n + MB + 3)) m.push_back(8'($urandom));
				end else begin
					repeat (n) m.push_back(8'($urandom));
					for (int i = 0; i < 4 && i < n; i++) m[i] = sb.exp_type[8 * i +: 8];
					sb.calc_mac(m, sb.tweak, n);
					foreach (sb.mac_buf[i]) m.push_back(sb.mac_buf[i]);
					case (shape)
						SHAPE_BAD_TYPE: begin
							at = $urandom_range(3);
							m[at] = m[at] ^ (8'h01 << $urandom_range(7));
						end
						SHAPE_BAD_MAC: begin
							at = n + $urandom_range(MB - 1);
							m[at] = m[at] ^ (8'h01 << $urandom_range(7));
						end
						SHAPE_BAD_LEN: begin
							if ($urandom_range(1))
								repeat ($urandom_range(1, 3)) m.push_back(8'($urandom));
							else
								repeat ($urandom_range(1, 3)) void'(m.pop_back());
						end
						default: ;
					endcase
				end
				send_msg(m, mark);
			end
			settle();
		end
		calm = 1'b0;

		if (sb.fails == 0 && sb.due_q.size() == 0)
			$display("xorshift_byte_mac_engine_tb: PASS");
		else
			$display("xorshift_byte_mac_engine_tb: FAIL");
		$finish;
	end

endmodule
